// ===== design/lscw_pkg.sv =====
// shared types, constants and codes of the lcd serial column writer
package lscw_pkg;

   localparam int CHIP_COUNT       = 6;
   localparam int COLUMNS_PER_BANK = 40;
   localparam int CHIP_BYTES       = 2 * COLUMNS_PER_BANK;
   localparam int BUFFER_BYTES     = CHIP_COUNT * CHIP_BYTES;
   localparam int BUF_ADDR_W       = $clog2(BUFFER_BYTES);
   localparam int CHIP_IDX_W       = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;

   // operation codes
   localparam logic [1:0] OP_REG_WRITE = 2'd0;
   localparam logic [1:0] OP_REG_READ  = 2'd1;
   localparam logic [1:0] OP_FETCH     = 2'd2;

   // i/o page register offsets
   localparam logic [5:0] REG_CHIP_SELECT = 6'h26;
   localparam logic [5:0] REG_SHIFT_A     = 6'h2a;
   localparam logic [5:0] REG_SHIFT_B     = 6'h2b;

   localparam logic [3:0] SELECT_MASK  = 4'h0f;
   localparam logic [3:0] SHIFT_BITS   = 4'd8;
   localparam int         BANK_BIT     = 6;
   localparam logic [7:0] COLUMN_MASK  = 8'h3f;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] address;
      logic [7:0] write_data;
      logic [2:0] panel_chip;
      logic [6:0] panel_offset;
   } req_type;

   typedef struct packed {
      logic [7:0] display_byte;
      logic [3:0] pending_bits;
   } rsp_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic clear_we;
      logic accept;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

// ===== design/lscw_ctrl.sv =====
// controller: buffer clearing sequence and request handshake
module lscw_ctrl
   import lscw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      out_blocked  = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (status.clear_last) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            req_stall  = out_blocked;
            cmd.accept = req_valid && !out_blocked;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      rsp_valid_in = cmd.accept || out_blocked;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/lscw_datapath.sv =====
// datapath: select, shift latch, per-chip pointers and the dot buffer
module lscw_datapath
   import lscw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req,
   output status_type status,
   output rsp_type    rsp
);

   logic [3:0] chip_select_ff, chip_select_in;
   logic [7:0] latched_ff, latched_in;
   logic [3:0] shift_count_ff, shift_count_in;
   logic       bank_high_ff [CHIP_COUNT];
   logic [5:0] column_ff    [CHIP_COUNT];

   logic [7:0] dot_mem [BUFFER_BYTES];
   logic [7:0] mem_rd_ff;
   logic       fetch_hit_ff;
   logic [3:0] pending_ff;

   logic [BUF_ADDR_W-1:0] clear_cnt_ff;

   logic [2:0]            chip_num;
   logic [2:0]            chip_k3;
   logic [CHIP_IDX_W-1:0] chip_k;
   logic                  chip_served;
   logic                  shift_hit;
   logic                  deliver;
   logic                  cmd_we;
   logic                  data_we;
   logic                  fetch_hit;
   logic [BUF_ADDR_W-1:0] data_addr;
   logic [BUF_ADDR_W-1:0] fetch_addr;
   logic                  mem_we;
   logic [BUF_ADDR_W-1:0] mem_wr_addr;
   logic [7:0]            mem_wr_data;

   always_comb begin
      chip_select_in = chip_select_ff;
      latched_in     = latched_ff;
      shift_count_in = shift_count_ff;
      shift_hit      = 1'b0;
      fetch_hit      = 1'b0;
      if (cmd.accept) begin
         case (req.operation)
            OP_REG_WRITE: begin
               if (req.address == REG_CHIP_SELECT) begin
                  chip_select_in = req.write_data[3:0] & SELECT_MASK;
               end else if (req.address == REG_SHIFT_A) begin
                  latched_in     = req.write_data;
                  shift_count_in = SHIFT_BITS;
               end
            end
            OP_REG_READ: begin
               if ((req.address == REG_SHIFT_A || req.address == REG_SHIFT_B)
                   && shift_count_ff != 4'd0) begin
                  shift_hit      = 1'b1;
                  shift_count_in = shift_count_ff - 4'd1;
               end
            end
            OP_FETCH: begin
               fetch_hit = (req.panel_chip < 3'(CHIP_COUNT))
                        && (req.panel_offset < 7'(CHIP_BYTES));
            end
            default: begin
            end
         endcase
      end
   end

   // byte delivery on the last shift read
   assign chip_num    = chip_select_ff[2:0];
   assign chip_k3     = chip_num - 3'd1;
   assign chip_k      = chip_k3[CHIP_IDX_W-1:0];
   assign chip_served = (chip_num != 3'd0) && (chip_num <= 3'(CHIP_COUNT));
   assign deliver     = shift_hit && (shift_count_ff == 4'd1) && chip_served;
   assign cmd_we      = deliver && chip_select_ff[3];
   assign data_we     = deliver && !chip_select_ff[3]
                     && (column_ff[chip_k] < 6'(COLUMNS_PER_BANK));

   assign data_addr  = BUF_ADDR_W'(chip_k) * BUF_ADDR_W'(CHIP_BYTES)
                     + (bank_high_ff[chip_k] ? BUF_ADDR_W'(COLUMNS_PER_BANK)
                                             : BUF_ADDR_W'(0))
                     + BUF_ADDR_W'(column_ff[chip_k]);
   assign fetch_addr = BUF_ADDR_W'(req.panel_chip) * BUF_ADDR_W'(CHIP_BYTES)
                     + BUF_ADDR_W'(req.panel_offset);

   assign mem_we      = cmd.clear_we || data_we;
   assign mem_wr_addr = cmd.clear_we ? clear_cnt_ff : data_addr;
   assign mem_wr_data = cmd.clear_we ? 8'd0 : latched_ff;

   assign status.clear_last = (clear_cnt_ff == BUF_ADDR_W'(BUFFER_BYTES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_select_ff <= '0;
         latched_ff     <= '0;
         shift_count_ff <= '0;
         clear_cnt_ff   <= '0;
         for (int i = 0; i < CHIP_COUNT; i++) begin
            bank_high_ff[i] <= 1'b0;
            column_ff[i]    <= '0;
         end
      end else begin
         chip_select_ff <= chip_select_in;
         latched_ff     <= latched_in;
         shift_count_ff <= shift_count_in;
         if (cmd.clear_we) begin
            clear_cnt_ff <= clear_cnt_ff + BUF_ADDR_W'(1);
         end
         if (cmd_we) begin
            bank_high_ff[chip_k] <= latched_ff[BANK_BIT];
            column_ff[chip_k]    <= 6'(latched_ff & COLUMN_MASK);
         end else if (data_we) begin
            column_ff[chip_k] <= column_ff[chip_k] + 6'd1;
         end
      end
   end

   // dot buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dot_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_hit) begin
         mem_rd_ff <= dot_mem[fetch_addr];
      end
   end

   // response payload, loaded only on accept so it holds while stalled
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         fetch_hit_ff <= fetch_hit;
         pending_ff   <= shift_count_in;
      end
   end

   assign rsp.display_byte = fetch_hit_ff ? mem_rd_ff : 8'd0;
   assign rsp.pending_bits = pending_ff;

endmodule

// ===== design/lcd_serial_column_writer.sv =====
// top level of the lcd serial column writer
//
//   channel   ports                         direction   moves
//   req       req_valid req_stall req_payload   in      one bus access or fetch
//   rsp       rsp_valid rsp_stall rsp_payload   out     one result per request
//
// one request per cycle sustained while results are not stalled; a result appears the cycle after its
// request, set by the registered read port of the dot buffer
// after reset the 480-byte dot buffer is cleared one byte a cycle, so no
// request is taken until the clearing pass ends
// the result register lets a new request in during the cycle its
// predecessor is taken; a stalled result holds and stalls the request side
module lcd_serial_column_writer
   import lscw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   // result channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // command and status between controller and datapath
   cmd_type    cmd;
   status_type status;

   // controller: clearing pass and handshake sequencing
   lscw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, per-chip column pointers and the dot buffer
   lscw_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .req    (req_payload),
      .status (status),
      .rsp    (rsp_payload)
   );

endmodule
